// ===== hdl/qesm_pkg.sv =====
// Package for the requantizing elementwise sum/max block.
// Holds field widths and configuration register indexes; no dependencies.
package qesm_pkg;

    localparam int ELEM_W     = 8;
    localparam int ZP_W       = 8;
    localparam int MUL_W      = 23;
    localparam int SHIFT_W    = 5;
    localparam int RESULT_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODE           = 3'd0;
    localparam t_cfg_idx CFG_ZERO_POINT_A   = 3'd1;
    localparam t_cfg_idx CFG_ZERO_POINT_B   = 3'd2;
    localparam t_cfg_idx CFG_MULTIPLIER_A   = 3'd3;
    localparam t_cfg_idx CFG_MULTIPLIER_B   = 3'd4;
    localparam t_cfg_idx CFG_SHIFT_A        = 3'd5;
    localparam t_cfg_idx CFG_SHIFT_B        = 3'd6;
    localparam t_cfg_idx CFG_OUT_ZERO_POINT = 3'd7;

    // Mode register values.
    localparam logic MODE_SUM = 1'b0;
    localparam logic MODE_MAX = 1'b1;

endpackage

// ===== hdl/qesm_in_if.sv =====
// Input channel of the requantizing elementwise block: one element pair per item.
// Depends on qesm_pkg for the element width.
interface qesm_in_if;
    logic                        valid;
    logic                        ready;
    logic [qesm_pkg::ELEM_W-1:0] elem_a;
    logic [qesm_pkg::ELEM_W-1:0] elem_b;

    modport source (output valid, output elem_a, output elem_b, input ready);
    modport sink   (input valid, input elem_a, input elem_b, output ready);
endinterface

// ===== hdl/qesm_out_if.sv =====
// Output channel of the requantizing elementwise block: one result per item.
// Depends on qesm_pkg for the result width.
interface qesm_out_if;
    logic                          valid;
    logic                          ready;
    logic [qesm_pkg::RESULT_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ===== hdl/quantized_eltwise_sum_max.sv =====
// Top level of the requantizing elementwise sum/max block.
// Depends on qesm_pkg, qesm_in_if and qesm_out_if.

// The block takes one pair of unsigned 8-bit elements per item and returns one
// requantized element per item, in order. It is a three-stage pipeline: the
// first stage removes the zero points and multiplies by the 23-bit scale
// multipliers, the second applies the per-input rounded shifts and forms the
// sum or the maximum, and the third applies the common rounded shift, adds the
// output zero point and saturates to [0, 2^OUT_BITS - 1]. One item is accepted
// every cycle while the output is not held back. Each item is registered in
// r_prod_a/b, then in r_acc, then in r_result, which is the presented result.
// Each stage advances whenever the stage after it is empty or moving, so
// bubbles are squeezed out and items keep entering while a finished result
// waits at the output. Configuration registers are written through a plain
// write port and must only change while no item is in flight.
module quantized_eltwise_sum_max #(
    parameter int OUT_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qesm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [qesm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    qesm_in_if.sink                           i_in_ch,
    qesm_out_if.source                        o_out_ch
);

    // Saturation bound in the width of the final datapath.
    localparam logic signed [34:0] SAT_HI = 35'((64'd1 << OUT_BITS) - 64'd1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic                             r_mode;
    logic [qesm_pkg::ZP_W-1:0]        r_zero_point_a;
    logic [qesm_pkg::ZP_W-1:0]        r_zero_point_b;
    logic [qesm_pkg::MUL_W-1:0]       r_multiplier_a;
    logic [qesm_pkg::MUL_W-1:0]       r_multiplier_b;
    logic [qesm_pkg::SHIFT_W-1:0]     r_shift_a;
    logic [qesm_pkg::SHIFT_W-1:0]     r_shift_b;
    logic [qesm_pkg::ZP_W-1:0]        r_out_zero_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= qesm_pkg::MODE_SUM;
            r_zero_point_a   <= '0;
            r_zero_point_b   <= '0;
            r_multiplier_a   <= '0;
            r_multiplier_b   <= '0;
            r_shift_a        <= '0;
            r_shift_b        <= '0;
            r_out_zero_point <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qesm_pkg::CFG_MODE:           r_mode           <= i_cfg_data[0];
                qesm_pkg::CFG_ZERO_POINT_A:   r_zero_point_a   <= i_cfg_data[7:0];
                qesm_pkg::CFG_ZERO_POINT_B:   r_zero_point_b   <= i_cfg_data[7:0];
                qesm_pkg::CFG_MULTIPLIER_A:   r_multiplier_a   <= i_cfg_data;
                qesm_pkg::CFG_MULTIPLIER_B:   r_multiplier_b   <= i_cfg_data;
                qesm_pkg::CFG_SHIFT_A:        r_shift_a        <= i_cfg_data[4:0];
                qesm_pkg::CFG_SHIFT_B:        r_shift_b        <= i_cfg_data[4:0];
                qesm_pkg::CFG_OUT_ZERO_POINT: r_out_zero_point <= i_cfg_data[7:0];
            endcase
        end
    end

    // Shift amounts derived from the configuration. The common shift is the
    // smaller shift minus one, so each input's own shift is always 1 to 32.
    logic [qesm_pkg::SHIFT_W-1:0] min_shift;
    logic [5:0]                   term_shift_a;
    logic [5:0]                   term_shift_b;

    assign min_shift    = (r_shift_a < r_shift_b) ? r_shift_a : r_shift_b;
    assign term_shift_a = {1'b0, r_shift_a} - {1'b0, min_shift} + 6'd1;
    assign term_shift_b = {1'b0, r_shift_b} - {1'b0, min_shift} + 6'd1;

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when its
    // content moves on in the same cycle.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    assign adv3 = !r_v3 || o_out_ch.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign i_in_ch.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in_ch.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: zero point removal and scaling. The difference is 9 bits
    // signed and the product of it with a 23-bit multiplier fits 32 bits.
    // ------------------------------------------------------------------
    logic signed [8:0]  diff_a, diff_b;
    logic signed [32:0] n_prod_a, n_prod_b;
    logic signed [31:0] r_prod_a, r_prod_b;

    assign diff_a   = $signed({1'b0, i_in_ch.elem_a}) - $signed({1'b0, r_zero_point_a});
    assign diff_b   = $signed({1'b0, i_in_ch.elem_b}) - $signed({1'b0, r_zero_point_b});
    assign n_prod_a = diff_a * $signed({1'b0, r_multiplier_a});
    assign n_prod_b = diff_b * $signed({1'b0, r_multiplier_b});

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && adv1) begin
            r_prod_a <= n_prod_a[31:0];
            r_prod_b <= n_prod_b[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-input rounded shift (add half, then floor shift), then
    // sum or maximum of the two scaled terms.
    // ------------------------------------------------------------------
    logic signed [33:0] rnd_a, rnd_b;
    logic signed [33:0] shf_a, shf_b;
    logic signed [31:0] term_a, term_b;
    logic signed [32:0] n_acc;
    logic signed [32:0] r_acc;

    assign rnd_a  = 34'(r_prod_a) + (34'sd1 <<< (term_shift_a - 6'd1));
    assign rnd_b  = 34'(r_prod_b) + (34'sd1 <<< (term_shift_b - 6'd1));
    assign shf_a  = rnd_a >>> term_shift_a;
    assign shf_b  = rnd_b >>> term_shift_b;
    assign term_a = shf_a[31:0];
    assign term_b = shf_b[31:0];

    always_comb begin
        if (r_mode == qesm_pkg::MODE_MAX) begin
            n_acc = (term_a > term_b) ? 33'(term_a) : 33'(term_b);
        end else begin
            n_acc = 33'(term_a) + 33'(term_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && adv2) begin
            r_acc <= n_acc;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: common rounded shift, output zero point and saturation.
    // When the smaller shift is zero the common shift is minus one, which
    // doubles the value without rounding; when it is one there is no shift.
    // ------------------------------------------------------------------
    logic signed [34:0]          acc_ext;
    logic signed [34:0]          common_val;
    logic signed [34:0]          with_zp;
    logic [qesm_pkg::SHIFT_W-1:0] common_shift;
    logic [qesm_pkg::RESULT_W-1:0] n_result;
    logic [qesm_pkg::RESULT_W-1:0] r_result;

    assign acc_ext      = 35'(r_acc);
    assign common_shift = min_shift - 5'd1;

    always_comb begin
        if (min_shift == '0) begin
            common_val = acc_ext <<< 1;
        end else if (min_shift == 5'd1) begin
            common_val = acc_ext;
        end else begin
            common_val = (acc_ext + (35'sd1 <<< (common_shift - 5'd1))) >>> common_shift;
        end
    end

    assign with_zp = common_val + $signed({27'd0, r_out_zero_point});

    always_comb begin
        if (with_zp < 35'sd0) begin
            n_result = '0;
        end else if (with_zp > SAT_HI) begin
            n_result = SAT_HI[qesm_pkg::RESULT_W-1:0];
        end else begin
            n_result = with_zp[qesm_pkg::RESULT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && adv3) begin
            r_result <= n_result;
        end
    end

    assign o_out_ch.valid  = r_v3;
    assign o_out_ch.result = r_result;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An accepted item always occupies the first stage in the next cycle.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> r_v1)
        else $error("accepted item did not enter the first stage");

    // An empty first stage never blocks the input.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_in_ch.ready)
        else $error("input stalled with an empty first stage");

    // When the output is taken, an item in stage 2 reaches the output.
    a_s2_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && o_out_ch.ready) |=> r_v3)
        else $error("stage 2 item lost when output was taken");

    // A presented result always lies within the saturation range.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid |-> ({27'd0, o_out_ch.result} <= SAT_HI))
        else $error("result exceeds the saturation bound");

endmodule

// ===== dv/tb_quantized_eltwise_sum_max.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for quantized_eltwise_sum_max: directed and random element pairs.
// Depends on qesm_pkg, qesm_in_if, qesm_out_if and the block itself.

module tb_quantized_eltwise_sum_max;

    localparam int OUT_BITS    = 8;
    // Idle cycles waited after the last result has come back, beyond the block's pipeline.
    localparam int PIPE_SLACK  = 8;
    localparam int STALL_PCT   = 7;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 106;

    // One full set of requantization registers.
    typedef struct {
        logic                         mode;
        logic [qesm_pkg::ZP_W-1:0]    zp_a;
        logic [qesm_pkg::ZP_W-1:0]    zp_b;
        logic [qesm_pkg::MUL_W-1:0]   mul_a;
        logic [qesm_pkg::MUL_W-1:0]   mul_b;
        logic [qesm_pkg::SHIFT_W-1:0] sh_a;
        logic [qesm_pkg::SHIFT_W-1:0] sh_b;
        logic [qesm_pkg::ZP_W-1:0]    out_zp;
    } t_qparams;

    // Keeps its own copy of the registers, works out the requantized element for each
    // accepted pair, and compares the block's results against them in order.
    class t_requant_checker;
        t_qparams                      regs;
        logic [qesm_pkg::RESULT_W-1:0] expected_q[$];
        int unsigned                   errors;
        int unsigned                   n_pairs;
        int unsigned                   n_max_pairs;
        int unsigned                   n_clipped;

        function new();
            regs = '{mode: qesm_pkg::MODE_SUM, zp_a: '0, zp_b: '0, mul_a: '0, mul_b: '0,
                     sh_a: '0, sh_b: '0, out_zp: '0};
            errors      = 0;
            n_pairs     = 0;
            n_max_pairs = 0;
            n_clipped   = 0;
        endfunction

        function void write_reg(qesm_pkg::t_cfg_idx idx,
                                logic [qesm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                qesm_pkg::CFG_MODE:           regs.mode   = data[0];
                qesm_pkg::CFG_ZERO_POINT_A:   regs.zp_a   = data[qesm_pkg::ZP_W-1:0];
                qesm_pkg::CFG_ZERO_POINT_B:   regs.zp_b   = data[qesm_pkg::ZP_W-1:0];
                qesm_pkg::CFG_MULTIPLIER_A:   regs.mul_a  = data[qesm_pkg::MUL_W-1:0];
                qesm_pkg::CFG_MULTIPLIER_B:   regs.mul_b  = data[qesm_pkg::MUL_W-1:0];
                qesm_pkg::CFG_SHIFT_A:        regs.sh_a   = data[qesm_pkg::SHIFT_W-1:0];
                qesm_pkg::CFG_SHIFT_B:        regs.sh_b   = data[qesm_pkg::SHIFT_W-1:0];
                qesm_pkg::CFG_OUT_ZERO_POINT: regs.out_zp = data[qesm_pkg::ZP_W-1:0];
                default: ;
            endcase
        endfunction

        // Round half up, then floor shift; a negative amount is a plain left shift.
        function longint round_shift(longint v, int s);
            if (s < 0)
                return v * (longint'(1) << (-s));
            if (s == 0)
                return v;
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function logic [qesm_pkg::RESULT_W-1:0] requantize(logic [qesm_pkg::ELEM_W-1:0] a,
                                                           logic [qesm_pkg::ELEM_W-1:0] b);
            int     common;
            longint ta;
            longint tb;
            longint acc;
            longint r;
            longint top;
            common = ((regs.sh_a < regs.sh_b) ? int'(regs.sh_a) : int'(regs.sh_b)) - 1;
            ta = round_shift((longint'(a) - longint'(regs.zp_a)) * longint'(regs.mul_a),
                             int'(regs.sh_a) - common);
            tb = round_shift((longint'(b) - longint'(regs.zp_b)) * longint'(regs.mul_b),
                             int'(regs.sh_b) - common);
            if (regs.mode == qesm_pkg::MODE_MAX)
                acc = (ta > tb) ? ta : tb;
            else
                acc = ta + tb;
            r   = round_shift(acc, common) + longint'(regs.out_zp);
            top = (longint'(1) << OUT_BITS) - 1;
            if (r < 0 || r > top)
                n_clipped++;
            if (r < 0)
                r = 0;
            if (r > top)
                r = top;
            return qesm_pkg::RESULT_W'(r);
        endfunction

        function void note_pair(logic [qesm_pkg::ELEM_W-1:0] a,
                                logic [qesm_pkg::ELEM_W-1:0] b);
            n_pairs++;
            if (regs.mode == qesm_pkg::MODE_MAX)
                n_max_pairs++;
            expected_q.push_back(requantize(a, b));
        endfunction

        function void check_result(logic [qesm_pkg::RESULT_W-1:0] got);
            logic [qesm_pkg::RESULT_W-1:0] want;
            if (expected_q.size() == 0) begin
                $display("%0t ns: result %0d arrived with nothing expected", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                $display("%0t ns: result mismatch, expected %0d, got %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [qesm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [qesm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    qesm_in_if  in_ch();
    qesm_out_if out_ch();

    quantized_eltwise_sum_max #(
        .OUT_BITS (OUT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    t_requant_checker chk = new();

    // When set, neither the sender nor the receiver stalls.
    logic        steady = 1'b0;
    int unsigned n_settings = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The receiver holds back at random, STALL_PCT percent of the time, except in the steady stretch.
    always @(posedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end

    // Everything is observed here, on the values that stood just before the clock edge:
    // register writes update the checker's copy, accepted pairs queue an expected
    // element, and accepted results are compared against the oldest one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                chk.write_reg(qesm_pkg::t_cfg_idx'(i_cfg_idx), i_cfg_data);
            if (in_ch.valid && in_ch.ready)
                chk.note_pair(in_ch.elem_a, in_ch.elem_b);
            if (out_ch.valid && out_ch.ready)
                chk.check_result(out_ch.result);
        end
    end

    // Presents one pair, possibly after a few idle cycles, and returns at the edge that
    // takes it. Ready is sampled at the falling edge, where it already holds the value
    // that the next rising edge sees. Valid stays high so that back-to-back items go out
    // without a gap.
    task automatic send_pair(input logic [qesm_pkg::ELEM_W-1:0] a,
                             input logic [qesm_pkg::ELEM_W-1:0] b);
        logic taken;
        while (!steady && $urandom_range(99) < STALL_PCT) begin
            in_ch.valid  <= 1'b0;
            in_ch.elem_a <= qesm_pkg::ELEM_W'($urandom);
            in_ch.elem_b <= qesm_pkg::ELEM_W'($urandom);
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.elem_a <= a;
        in_ch.elem_b <= b;
        do begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Stops sending and waits until every queued element has come back, then lets the
    // pipeline settle so that a register write cannot touch an item in flight.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (chk.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    // Writes all eight registers on consecutive cycles; only legal while idle.
    task automatic apply_setting(input t_qparams p);
        logic [qesm_pkg::CFG_DATA_W-1:0] vals[8];
        qesm_pkg::t_cfg_idx              idxs[8];
        idxs = '{qesm_pkg::CFG_MODE, qesm_pkg::CFG_ZERO_POINT_A, qesm_pkg::CFG_ZERO_POINT_B,
                 qesm_pkg::CFG_MULTIPLIER_A, qesm_pkg::CFG_MULTIPLIER_B,
                 qesm_pkg::CFG_SHIFT_A, qesm_pkg::CFG_SHIFT_B,
                 qesm_pkg::CFG_OUT_ZERO_POINT};
        vals = '{qesm_pkg::CFG_DATA_W'(p.mode), qesm_pkg::CFG_DATA_W'(p.zp_a),
                 qesm_pkg::CFG_DATA_W'(p.zp_b), qesm_pkg::CFG_DATA_W'(p.mul_a),
                 qesm_pkg::CFG_DATA_W'(p.mul_b), qesm_pkg::CFG_DATA_W'(p.sh_a),
                 qesm_pkg::CFG_DATA_W'(p.sh_b), qesm_pkg::CFG_DATA_W'(p.out_zp)};
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic t_qparams make_setting(logic mode, int zp_a, int zp_b, int mul_a,
                                              int mul_b, int sh_a, int sh_b, int out_zp);
        t_qparams p;
        p.mode   = mode;
        p.zp_a   = qesm_pkg::ZP_W'(zp_a);
        p.zp_b   = qesm_pkg::ZP_W'(zp_b);
        p.mul_a  = qesm_pkg::MUL_W'(mul_a);
        p.mul_b  = qesm_pkg::MUL_W'(mul_b);
        p.sh_a   = qesm_pkg::SHIFT_W'(sh_a);
        p.sh_b   = qesm_pkg::SHIFT_W'(sh_b);
        p.out_zp = qesm_pkg::ZP_W'(out_zp);
        return p;
    endfunction

    // A multiplier near 2^shift keeps the scale close to one, so most results land
    // inside the output range; now and then a fully random one drives saturation.
    function automatic logic [qesm_pkg::MUL_W-1:0] pick_multiplier(
            logic [qesm_pkg::SHIFT_W-1:0] sh);
        longint top;
        longint lo;
        longint hi;
        if ($urandom_range(9) == 0)
            return qesm_pkg::MUL_W'($urandom);
        top = (longint'(1) << qesm_pkg::MUL_W) - 1;
        hi  = (longint'(1) << sh) * 2;
        if (hi > top)
            hi = top;
        lo  = (longint'(1) << sh) / 16;
        if (lo < 1)
            lo = 1;
        if (lo > hi)
            lo = hi;
        return qesm_pkg::MUL_W'($urandom_range(int'(hi), int'(lo)));
    endfunction

    function automatic logic [qesm_pkg::SHIFT_W-1:0] pick_shift();
        if ($urandom_range(3) == 0)
            return qesm_pkg::SHIFT_W'($urandom_range(31));
        return qesm_pkg::SHIFT_W'($urandom_range(23));
    endfunction

    function automatic t_qparams random_setting();
        t_qparams p;
        p.mode   = ($urandom_range(1) == 1) ? qesm_pkg::MODE_MAX : qesm_pkg::MODE_SUM;
        p.zp_a   = qesm_pkg::ZP_W'($urandom);
        p.zp_b   = qesm_pkg::ZP_W'($urandom);
        p.out_zp = qesm_pkg::ZP_W'($urandom);
        p.sh_a   = pick_shift();
        p.sh_b   = pick_shift();
        p.mul_a  = pick_multiplier(p.sh_a);
        p.mul_b  = pick_multiplier(p.sh_b);
        return p;
    endfunction

    // Mostly uniform elements, with a share pinned to the rails or hugging the zero point
    // so that the sign of the difference flips often.
    function automatic logic [qesm_pkg::ELEM_W-1:0] pick_elem(
            logic [qesm_pkg::ZP_W-1:0] zp);
        int unsigned roll;
        int          v;
        roll = $urandom_range(99);
        if (roll < 70)
            return qesm_pkg::ELEM_W'($urandom);
        if (roll < 85) begin
            v = int'(zp) + int'($urandom_range(6)) - 3;
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            return qesm_pkg::ELEM_W'(v);
        end
        return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    endfunction

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.elem_a <= '0;
        in_ch.elem_b <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Straight out of reset every register is zero, so both terms vanish.
        send_pair(8'hFF, 8'h00);
        send_pair(8'h00, 8'hFF);
        wait_for_results();

        // Both shifts at zero: the common shift is minus one and the final step becomes a
        // left shift. Full multipliers make the widest products, and the rails saturate.
        apply_setting(make_setting(qesm_pkg::MODE_SUM, 0, 255, 8388607, 8388607, 0, 0, 128));
        send_pair(8'h00, 8'h00);
        send_pair(8'hFF, 8'hFF);
        send_pair(8'h00, 8'hFF);
        send_pair(8'hFF, 8'h00);
        send_pair(8'h80, 8'h7F);
        wait_for_results();

        // Max of two negative terms: the larger one must win, not some start value.
        // Shifts at the top of their range, one multiplier full and the other minimal.
        apply_setting(make_setting(qesm_pkg::MODE_MAX, 200, 100, 8388607, 1, 31, 31, 7));
        send_pair(8'h00, 8'h00);
        send_pair(8'hFF, 8'hFF);
        send_pair(8'hC8, 8'h64);
        send_pair(8'hC7, 8'hFF);
        wait_for_results();

        // Smallest shift of one puts the common shift at zero, so the last rounding step
        // passes the sum straight through.
        apply_setting(make_setting(qesm_pkg::MODE_SUM, 128, 128, 1, 1 << 20, 1, 20, 128));
        send_pair(8'h81, 8'h7F);
        send_pair(8'h83, 8'h80);
        send_pair(8'h7D, 8'hA0);
        send_pair(8'h00, 8'h00);
        send_pair(8'hFF, 8'hFF);
        wait_for_results();

        // Max mode with the left-shifting final step and a full output zero point.
        apply_setting(make_setting(qesm_pkg::MODE_MAX, 0, 255, 1, 32, 0, 5, 255));
        send_pair(8'h03, 8'hF0);
        send_pair(8'hFF, 8'h00);
        send_pair(8'h00, 8'hFF);
        send_pair(8'h01, 8'h01);
        wait_for_results();

        // Random phases: a fresh register setting each time, written while idle.
        // The fourth phase runs with no stalls on either side, and the sixth pauses
        // halfway until the pipeline has emptied.
        for (int ph = 0; ph < PHASES; ph++) begin
            apply_setting(random_setting());
            steady = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    wait_for_results();
                send_pair(pick_elem(chk.regs.zp_a), pick_elem(chk.regs.zp_b));
            end
            steady = 1'b0;
            wait_for_results();
        end

        if (chk.expected_q.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived",
                     $time, chk.expected_q.size());
            chk.errors++;
        end
        $display("Ran %0d element pairs under %0d register settings (%0d in max mode).",
                 chk.n_pairs, n_settings, chk.n_max_pairs);
        $display("%0d results hit the saturation limits; %0d mismatches seen.",
                 chk.n_clipped, chk.errors);
        if (chk.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: ends the run with a failure if it has not finished by then.
    initial begin
        #5000000;
        $display("Timed out with %0d results outstanding", chk.expected_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
